// ----- hw/rtl/hsl_to_rgb_converter_assert.svh -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define HSL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hsl assertion failed: same-cycle check");

// next-cycle implication under reset
`define HSL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hsl assertion failed: next-cycle check");

`else

`define HSL_ASSERT_SAME(label, clk, rstn, ante, cons)
`define HSL_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/hsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared payload types and fixed constants of the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } hsl_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // signed angle wide enough for -120..631
    localparam int ANGLE_W = 11;
    // ramp weight 0..60
    localparam int K_W     = 7;
    // p, q and q - p in units of 1/65536
    localparam int PQ_W    = 16;
    // 60 * p + d * k
    localparam int NUM_W   = 22;
    // numerator after the divide by 1024
    localparam int X_W     = 12;
    localparam int RECIP_W = 16;
    localparam int QUO_W   = 9;

    localparam logic signed [ANGLE_W-1:0] HUE_OFFSET = 11'sd120;
    localparam logic signed [ANGLE_W-1:0] FULL_TURN  = 11'sd360;

    localparam logic [8:0] SEG_RISE_END = 9'd60;
    localparam logic [8:0] SEG_HIGH_END = 9'd180;
    localparam logic [8:0] SEG_FALL_END = 9'd240;

    localparam logic [K_W-1:0] K_FULL = 7'd60;
    localparam logic [K_W-1:0] K_ZERO = 7'd0;

    // floor(x / 15) = (x * 34953) >> 19 for x < 4096
    localparam logic [RECIP_W-1:0] RECIP_15    = 16'd34953;
    localparam int                 RECIP_SHIFT = 19;
    localparam int                 DIV_SHIFT   = 10;

    localparam logic [7:0] CHAN_MAX = 8'd255;

endpackage

// ----- hw/rtl/hsl_to_rgb_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL pixel to RGB pixel, six-stage pipeline, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one HSL request (hue in degrees,
//   saturation and lightness in 1/256 steps); m_valid/m_ready/m_data
//   carry the RGB result, one result per request, in request order.
//   Throughput is one pixel per cycle unless the receiver stalls; the
//   rate is set by the six register stages (l*s product, q/p, base and
//   difference, d*k product, divide by 1024, reciprocal multiply by
//   1/15) that all advance together.
//   When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes and s_ready drops; nothing is lost or repeated and
//   m_data holds. Stages holding bubbles never block the flow.
//   Reset (aresetn low, synchronous) clears all stage valid bits; data
//   registers are not reset. The block has no configuration.
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hsl_pkg::hsl_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hsl_pkg::rgb_t     m_data
);

    localparam int DEPTH = 6;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             pipe_en;

    // stage 1
    logic [15:0]                  ls_reg;
    logic [7:0]                   l_reg;
    logic [7:0]                   s_reg;
    logic [hsl_pkg::K_W-1:0]      k1_reg [3];
    logic [hsl_pkg::K_W-1:0]      k1_next [3];
    logic signed [hsl_pkg::ANGLE_W-1:0] ang [3];
    logic signed [hsl_pkg::ANGLE_W-1:0] hue_s;

    // stage 2
    logic [hsl_pkg::PQ_W-1:0]     q_reg;
    logic [hsl_pkg::PQ_W-1:0]     p_reg;
    logic [hsl_pkg::K_W-1:0]      k2_reg [3];
    logic [16:0]                  q_wide;
    logic [16:0]                  p_wide;

    // stage 3
    logic [hsl_pkg::PQ_W-1:0]     d_reg;
    logic [hsl_pkg::NUM_W-1:0]    base_reg;
    logic [hsl_pkg::K_W-1:0]      k3_reg [3];
    logic [hsl_pkg::NUM_W-1:0]    base_next;

    logic [7:0]                   chan [3];

    assign pipe_en  = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready  = pipe_en;
    assign m_valid  = vld_reg[DEPTH-1];
    assign vld_next = {vld_reg[DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // channel angles: hue + 120, hue, hue - 120
    assign hue_s  = signed'({2'b00, s_data.hue});
    assign ang[0] = hue_s + hsl_pkg::HUE_OFFSET;
    assign ang[1] = hue_s;
    assign ang[2] = hue_s - hsl_pkg::HUE_OFFSET;

    for (genvar c = 0; c < 3; c++) begin : g_ramp
        hsl_ramp_sel u_ramp (
            .angle  (ang[c]),
            .weight (k1_next[c])
        );
    end

    // q and p in units of 1/65536
    always_comb begin
        if (!l_reg[7]) begin
            q_wide = {1'b0, l_reg, 8'b0} + {1'b0, ls_reg};
        end else begin
            q_wide = {1'b0, l_reg, 8'b0} + {1'b0, s_reg, 8'b0} - {1'b0, ls_reg};
        end
        p_wide = {l_reg, 9'b0} - q_wide;
    end

    // 60 * p as 64p - 4p
    assign base_next = {p_reg, 6'b0} - {4'b0, p_reg, 2'b0};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ls_reg   <= {8'b0, s_data.lightness} * {8'b0, s_data.saturation};
            l_reg    <= s_data.lightness;
            s_reg    <= s_data.saturation;
            k1_reg   <= k1_next;
            q_reg    <= q_wide[hsl_pkg::PQ_W-1:0];
            p_reg    <= p_wide[hsl_pkg::PQ_W-1:0];
            k2_reg   <= k1_reg;
            d_reg    <= q_reg - p_reg;
            base_reg <= base_next;
            k3_reg   <= k2_reg;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        hsl_chan_pipe u_chan (
            .aclk   (aclk),
            .en     (pipe_en),
            .base   (base_reg),
            .diff   (d_reg),
            .weight (k3_reg[c]),
            .chan   (chan[c])
        );
    end

    assign m_data.red   = chan[0];
    assign m_data.green = chan[1];
    assign m_data.blue  = chan[2];

    // ramp weights never exceed a full segment
    `HSL_ASSERT_SAME(a_k_range, aclk, aresetn, vld_reg[0], (k1_reg[0] <= hsl_pkg::K_FULL) && (k1_reg[1] <= hsl_pkg::K_FULL) && (k1_reg[2] <= hsl_pkg::K_FULL))
    // lower ramp level never above the upper one
    `HSL_ASSERT_SAME(a_p_le_q, aclk, aresetn, vld_reg[1], p_reg <= q_reg)
    // a frozen pipeline keeps every item in place
    `HSL_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !pipe_en, vld_reg == $past(vld_reg))

endmodule

// ----- hw/rtl/hsl_ramp_sel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_ramp_sel
// Wraps one channel angle once and picks its ramp weight k (0..60).
// ----------------------------------------------------------------------------
module hsl_ramp_sel (
    input  logic signed [hsl_pkg::ANGLE_W-1:0] angle,
    output logic        [hsl_pkg::K_W-1:0]     weight
);

    logic signed [hsl_pkg::ANGLE_W-1:0] wrapped;
    logic        [8:0]                  t;
    logic        [8:0]                  fall;

    always_comb begin
        if (angle < 0) begin
            wrapped = angle + hsl_pkg::FULL_TURN;
        end else if (angle > hsl_pkg::FULL_TURN) begin
            wrapped = angle - hsl_pkg::FULL_TURN;
        end else begin
            wrapped = angle;
        end
    end

    // wrapped angle always lands in 0..360
    assign t    = wrapped[8:0];
    assign fall = hsl_pkg::SEG_FALL_END - t;

    always_comb begin
        if (t < hsl_pkg::SEG_RISE_END) begin
            weight = {1'b0, t[5:0]};
        end else if (t < hsl_pkg::SEG_HIGH_END) begin
            weight = hsl_pkg::K_FULL;
        end else if (t < hsl_pkg::SEG_FALL_END) begin
            weight = fall[hsl_pkg::K_W-1:0];
        end else begin
            weight = hsl_pkg::K_ZERO;
        end
    end

endmodule

// ----- hw/rtl/hsl_chan_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_chan_pipe
// Three-stage channel back end: d * k, add base and divide by 1024,
// divide by 15 through a reciprocal multiply, then saturate.
// ----------------------------------------------------------------------------
module hsl_chan_pipe (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [hsl_pkg::NUM_W-1:0]     base,
    input  logic [hsl_pkg::PQ_W-1:0]      diff,
    input  logic [hsl_pkg::K_W-1:0]       weight,
    output logic [7:0]                    chan
);

    localparam int PROD_W = hsl_pkg::PQ_W + hsl_pkg::K_W;
    localparam int QP_W   = hsl_pkg::X_W + hsl_pkg::RECIP_W;

    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W-1:0]          prod_next;
    logic [hsl_pkg::NUM_W-1:0]  base_reg;
    logic [hsl_pkg::X_W-1:0]    x_reg;
    logic [hsl_pkg::X_W-1:0]    x_next;
    logic [QP_W-1:0]            quo_reg;
    logic [QP_W-1:0]            quo_next;
    logic [PROD_W-1:0]          num;
    logic [hsl_pkg::QUO_W-1:0]  quo;

    assign prod_next = {{hsl_pkg::K_W{1'b0}}, diff} * {{hsl_pkg::PQ_W{1'b0}}, weight};
    assign num       = {{(PROD_W-hsl_pkg::NUM_W){1'b0}}, base_reg} + prod_reg;
    assign x_next    = num[hsl_pkg::DIV_SHIFT +: hsl_pkg::X_W];
    assign quo_next  = {{hsl_pkg::RECIP_W{1'b0}}, x_reg}
                     * {{hsl_pkg::X_W{1'b0}}, hsl_pkg::RECIP_15};

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            base_reg <= base;
            x_reg    <= x_next;
            quo_reg  <= quo_next;
        end
    end

    assign quo  = quo_reg[hsl_pkg::RECIP_SHIFT +: hsl_pkg::QUO_W];
    assign chan = quo[hsl_pkg::QUO_W-1] ? hsl_pkg::CHAN_MAX : quo[7:0];

endmodule
